FILE: hw/rtl/bts_pkg.sv
// ============================================================================
// bts_pkg
// Shared types and constants of the bilinear texel sampler: field widths,
// command kinds and the status word of the command queue.
// ============================================================================
package bts_pkg;

   localparam int FRAC_BITS      = 16;
   localparam int COORD_BITS     = 18;
   localparam int UV_BITS        = 17;
   localparam int TEXEL_IN_BITS  = 16;
   localparam int INDEX_BITS     = 8;
   localparam int DIM_BITS       = 9;
   localparam int COVERAGE_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int KIND_BITS      = 2;

   // 1.0 in Q16
   localparam logic [UV_BITS-1:0] UV_ONE = 17'h10000;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_LOAD   = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_ZERO   = 2'd2
   } kind_type;

   localparam int CMD_DEPTH    = 4;
   localparam int CMD_PTR_BITS = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_BITS = $clog2(CMD_DEPTH + 1);

   localparam int OUT_DEPTH    = 8;
   localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic [CMD_CNT_BITS-1:0] count;
      logic                    nonempty;
   } queue_status_type;

endpackage

FILE: hw/rtl/bilinear_texel_sampler_core.sv
// ============================================================================
// bilinear_texel_sampler_core
// Bilinear coverage sampler with clamp-to-edge addressing over a texel store.
// ============================================================================
// Takes one item per cycle, loads and samples alike, as long as results are
// drained. A load writes one texel and returns nothing; a sample returns one
// Q0.16 coverage value (zero while texture_ready is 0). A sample's result
// passes one intake stage, the command queue, a registered fetch from the
// texel store and the arithmetic stages before the result buffer. The
// sustained rate of one item per cycle, while results are drained, is set by
// the texel store, split by column and row parity into four single-port
// banks so the four neighbors of a sample are read together. The store has
// no clearing pass; texels are undefined until loaded. Loads and samples
// take effect in the order they were accepted.
// ============================================================================
module bilinear_texel_sampler_core #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int TEXEL_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_en,
   input  logic [bts_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [bts_pkg::DIM_BITS-1:0]            csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_mode,
   input  logic [bts_pkg::INDEX_BITS-1:0]          req_texel_column,
   input  logic [bts_pkg::INDEX_BITS-1:0]          req_texel_row,
   input  logic [bts_pkg::TEXEL_IN_BITS-1:0]       req_texel_value,
   input  logic signed [bts_pkg::COORD_BITS-1:0]   req_coord_u,
   input  logic signed [bts_pkg::COORD_BITS-1:0]   req_coord_v,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [bts_pkg::COVERAGE_BITS-1:0]       rsp_coverage
);
   import bts_pkg::*;

   localparam int X_BITS = $clog2(MAX_WIDTH);
   localparam int Y_BITS = $clog2(MAX_HEIGHT);
   localparam int CMD_W  = KIND_BITS + TEXEL_BITS + 2 * Y_BITS + 2 * X_BITS
                           + 2 * FRAC_BITS;

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   logic [CMD_W-1:0] q_push_data;
   logic [CMD_W-1:0] q_head_data;

   bts_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .TEXEL_BITS (TEXEL_BITS),
      .CMD_W      (CMD_W)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_texel_column (req_texel_column),
      .req_texel_row    (req_texel_row),
      .req_texel_value  (req_texel_value),
      .req_coord_u      (req_coord_u),
      .req_coord_v      (req_coord_v),
      .q_status         (q_status),
      .push_valid       (q_push),
      .push_data        (q_push_data)
   );

   bts_queue #(
      .DATA_W (CMD_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push),
      .push_data  (q_push_data),
      .pop        (q_pop),
      .head_data  (q_head_data),
      .status     (q_status)
   );

   bts_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .TEXEL_BITS (TEXEL_BITS),
      .CMD_W      (CMD_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .head_data    (q_head_data),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_coverage (rsp_coverage)
   );

`ifndef SYNTHESIS
   // intake credit must keep the queue from overflowing
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> ((32'(q_status.count) < CMD_DEPTH) || q_pop))
      else $error("command queue overflow");

   a_queue_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_status.nonempty)
      else $error("command queue popped while empty");

   // an item held in intake is pushed on the next edge, so ready drops at full
   a_ready_reserves_room: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (32'(q_status.count) < CMD_DEPTH || q_pop))
      else $error("item accepted without queue room");
`endif

endmodule

FILE: hw/rtl/bts_queue.sv
// ============================================================================
// bts_queue
// Short command queue between the front end and the back end of the sampler.
// ============================================================================
module bts_queue #(
   parameter int DATA_W = 82
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  logic [DATA_W-1:0]           push_data,
   input  logic                        pop,
   output logic [DATA_W-1:0]           head_data,
   output bts_pkg::queue_status_type   status
);
   import bts_pkg::*;

   logic [DATA_W-1:0]       entry_ff [CMD_DEPTH];
   logic [CMD_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + CMD_PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + CMD_PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + CMD_CNT_BITS'(push_valid) - CMD_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data       = entry_ff[rd_ptr_ff];
   assign status.count    = count_ff;
   assign status.nonempty = (count_ff != '0);

endmodule

FILE: hw/rtl/bts_front.sv
// ============================================================================
// bts_front
// Front end: configuration registers, item intake and classification, UV
// clamp and scale to texel coordinates, command push into the queue.
// ============================================================================
module bts_front #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int TEXEL_BITS = 16,
   parameter int CMD_W      = 82
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_en,
   input  logic [bts_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [bts_pkg::DIM_BITS-1:0]            csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_mode,
   input  logic [bts_pkg::INDEX_BITS-1:0]          req_texel_column,
   input  logic [bts_pkg::INDEX_BITS-1:0]          req_texel_row,
   input  logic [bts_pkg::TEXEL_IN_BITS-1:0]       req_texel_value,
   input  logic signed [bts_pkg::COORD_BITS-1:0]   req_coord_u,
   input  logic signed [bts_pkg::COORD_BITS-1:0]   req_coord_v,
   input  bts_pkg::queue_status_type               q_status,
   output logic                                    push_valid,
   output logic [CMD_W-1:0]                        push_data
);
   import bts_pkg::*;

   localparam int X_BITS    = $clog2(MAX_WIDTH);
   localparam int Y_BITS    = $clog2(MAX_HEIGHT);
   localparam int SX_W      = UV_BITS + X_BITS;
   localparam int SY_W      = UV_BITS + Y_BITS;
   localparam int CRED_BITS = CMD_CNT_BITS + 1;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TEXTURE_READY = 2'd2;

   typedef struct packed {
      kind_type                kind;
      logic [TEXEL_BITS-1:0]   value;
      logic [Y_BITS-1:0]       y1;
      logic [Y_BITS-1:0]       y0;
      logic [X_BITS-1:0]       x1;
      logic [X_BITS-1:0]       x0;
      logic [FRAC_BITS-1:0]    fy;
      logic [FRAC_BITS-1:0]    fx;
   } cmd_type;

   function automatic logic [UV_BITS-1:0] clamp_uv(input logic [COORD_BITS-1:0] raw);
      logic [UV_BITS-1:0] mag;
      mag = raw[UV_BITS-1:0];
      if (raw[COORD_BITS-1]) begin
         return '0;
      end
      if (mag > UV_ONE) begin
         return UV_ONE;
      end
      return mag;
   endfunction

   // configuration
   logic [DIM_BITS-1:0] image_width_ff;
   logic [DIM_BITS-1:0] image_height_ff;
   logic                texture_ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= DIM_BITS'(1);
         image_height_ff  <= DIM_BITS'(1);
         texture_ready_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_wdata;
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_wdata;
            CSR_TEXTURE_READY: texture_ready_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // last usable column and row, with zero read as one and saturation at max
   logic [X_BITS-1:0] wm1;
   logic [Y_BITS-1:0] hm1;

   always_comb begin
      if (image_width_ff == '0) begin
         wm1 = '0;
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         wm1 = X_BITS'(MAX_WIDTH - 1);
      end else begin
         wm1 = X_BITS'(image_width_ff - DIM_BITS'(1));
      end
      if (image_height_ff == '0) begin
         hm1 = '0;
      end else if (32'(image_height_ff) > MAX_HEIGHT) begin
         hm1 = Y_BITS'(MAX_HEIGHT - 1);
      end else begin
         hm1 = Y_BITS'(image_height_ff - DIM_BITS'(1));
      end
   end

   // intake stage
   logic                  f1_valid_ff, f1_valid_in;
   kind_type              f1_kind_ff, f1_kind_in;
   logic [X_BITS-1:0]     f1_col_ff;
   logic [Y_BITS-1:0]     f1_row_ff;
   logic [TEXEL_BITS-1:0] f1_value_ff;
   logic [UV_BITS-1:0]    f1_u_ff;
   logic [UV_BITS-1:0]    f1_v_ff;
   logic                  accept;
   logic                  load_in_range;

   // room is reserved in the queue for the item held in the intake stage
   assign req_ready = (CRED_BITS'(q_status.count) + CRED_BITS'(f1_valid_ff))
                      < CRED_BITS'(CMD_DEPTH);
   assign accept    = req_valid & req_ready;

   always_comb begin
      load_in_range = (32'(req_texel_column) < MAX_WIDTH) &&
                      (32'(req_texel_row) < MAX_HEIGHT);
      // loads outside the store are dropped here
      f1_valid_in   = accept && ((req_mode == MODE_SAMPLE) || load_in_range);
      if (req_mode == MODE_LOAD) begin
         f1_kind_in = KIND_LOAD;
      end else if (texture_ready_ff) begin
         f1_kind_in = KIND_SAMPLE;
      end else begin
         f1_kind_in = KIND_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_kind_ff  <= f1_kind_in;
         f1_col_ff   <= X_BITS'(req_texel_column);
         f1_row_ff   <= Y_BITS'(req_texel_row);
         f1_value_ff <= TEXEL_BITS'(req_texel_value);
         f1_u_ff     <= clamp_uv(req_coord_u);
         f1_v_ff     <= clamp_uv(req_coord_v);
      end
   end

   // scale to texel space and build the command
   logic [SX_W-1:0]   sx;
   logic [SY_W-1:0]   sy;
   logic [X_BITS-1:0] sx0, sx1;
   logic [Y_BITS-1:0] sy0, sy1;
   cmd_type           cmd;

   always_comb begin
      sx  = SX_W'(f1_u_ff) * SX_W'(wm1);
      sy  = SY_W'(f1_v_ff) * SY_W'(hm1);
      sx0 = sx[FRAC_BITS +: X_BITS];
      sy0 = sy[FRAC_BITS +: Y_BITS];
      sx1 = (sx0 < wm1) ? sx0 + X_BITS'(1) : wm1;
      sy1 = (sy0 < hm1) ? sy0 + Y_BITS'(1) : hm1;

      cmd      = '0;
      cmd.kind = f1_kind_ff;
      case (f1_kind_ff)
         KIND_LOAD: begin
            cmd.value = f1_value_ff;
            cmd.x0    = f1_col_ff;
            cmd.x1    = f1_col_ff;
            cmd.y0    = f1_row_ff;
            cmd.y1    = f1_row_ff;
         end
         KIND_SAMPLE: begin
            cmd.x0 = sx0;
            cmd.x1 = sx1;
            cmd.y0 = sy0;
            cmd.y1 = sy1;
            cmd.fx = sx[FRAC_BITS-1:0];
            cmd.fy = sy[FRAC_BITS-1:0];
         end
         default: ;
      endcase
   end

   assign push_valid = f1_valid_ff;
   assign push_data  = cmd;

endmodule

FILE: hw/rtl/bts_back.sv
// ============================================================================
// bts_back
// Back end: four parity banks of the texel store, texel fetch, two-level
// lerp pipeline and the result buffer in front of the response channel.
// ============================================================================
module bts_back #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int TEXEL_BITS = 16,
   parameter int CMD_W      = 82
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bts_pkg::queue_status_type            q_status,
   input  logic [CMD_W-1:0]                     head_data,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [bts_pkg::COVERAGE_BITS-1:0]    rsp_coverage
);
   import bts_pkg::*;

   localparam int X_BITS     = $clog2(MAX_WIDTH);
   localparam int Y_BITS     = $clog2(MAX_HEIGHT);
   localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
   localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
   localparam int BANK_DEPTH = HALF_W * HALF_H;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int PROD_W     = TEXEL_BITS + UV_BITS;
   localparam int LERP_W     = (TEXEL_BITS + UV_BITS + 1 > 32) ?
                               TEXEL_BITS + UV_BITS + 1 : 32;
   localparam int PROD2_W    = COVERAGE_BITS + UV_BITS;
   localparam int SUM2_W     = PROD2_W + 1;
   localparam int RES_W      = SUM2_W - FRAC_BITS;
   localparam int OCW        = OUT_CNT_BITS + 1;

   typedef struct packed {
      kind_type                kind;
      logic [TEXEL_BITS-1:0]   value;
      logic [Y_BITS-1:0]       y1;
      logic [Y_BITS-1:0]       y0;
      logic [X_BITS-1:0]       x1;
      logic [X_BITS-1:0]       x0;
      logic [FRAC_BITS-1:0]    fy;
      logic [FRAC_BITS-1:0]    fx;
   } cmd_type;

   cmd_type head;
   assign head = head_data;

   // pipeline valids
   logic b1_valid_ff, b2_valid_ff, b3_valid_ff, b4_valid_ff;
   logic [OUT_CNT_BITS-1:0] out_count_ff, out_count_in;
   logic inflight_ok;
   logic load_pop, sample_pop;

   // every sample in flight owns a slot of the result buffer
   assign inflight_ok = (OCW'(out_count_ff) + OCW'(b1_valid_ff) + OCW'(b2_valid_ff) +
                         OCW'(b3_valid_ff) + OCW'(b4_valid_ff)) < OCW'(OUT_DEPTH);

   assign pop        = q_status.nonempty && ((head.kind == KIND_LOAD) || inflight_ok);
   assign load_pop   = pop && (head.kind == KIND_LOAD);
   assign sample_pop = pop && (head.kind != KIND_LOAD);

   // texel banks, split by column and row parity
   logic [TEXEL_BITS-1:0] bank_rd [4];

   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic BX = 1'(b % 2);
      localparam logic BY = 1'(b / 2);

      logic [TEXEL_BITS-1:0] mem_ff [BANK_DEPTH];
      logic [TEXEL_BITS-1:0] rd_ff;
      logic [X_BITS-1:0]     xsel;
      logic [Y_BITS-1:0]     ysel;
      logic [BANK_AW-1:0]    addr;
      logic                  we;

      always_comb begin
         xsel = (head.x0[0] == BX) ? head.x0 : head.x1;
         ysel = (head.y0[0] == BY) ? head.y0 : head.y1;
         addr = BANK_AW'(32'(ysel >> 1) * HALF_W + 32'(xsel >> 1));
         we   = load_pop && (head.x0[0] == BX) && (head.y0[0] == BY);
      end

      always_ff @(posedge clock) begin
         if (we) begin
            mem_ff[addr] <= head.value;
         end
         rd_ff <= mem_ff[addr];
      end

      assign bank_rd[b] = rd_ff;
   end

   // stage 1: fetch
   logic                 b1_zero_ff;
   logic                 b1_x0_odd_ff, b1_x1_odd_ff, b1_y0_odd_ff, b1_y1_odd_ff;
   logic [FRAC_BITS-1:0] b1_fx_ff, b1_fy_ff;

   always_ff @(posedge clock) begin
      if (sample_pop) begin
         b1_zero_ff   <= (head.kind == KIND_ZERO);
         b1_x0_odd_ff <= head.x0[0];
         b1_x1_odd_ff <= head.x1[0];
         b1_y0_odd_ff <= head.y0[0];
         b1_y1_odd_ff <= head.y1[0];
         b1_fx_ff     <= head.fx;
         b1_fy_ff     <= head.fy;
      end
   end

   // stage 2: row lerp products
   logic [TEXEL_BITS-1:0] tl, tr, bl, br;
   logic [UV_BITS-1:0]    inv_fx;
   logic                  b2_zero_ff;
   logic [FRAC_BITS-1:0]  b2_fy_ff;
   logic [PROD_W-1:0]     b2_p_tl_ff, b2_p_tr_ff, b2_p_bl_ff, b2_p_br_ff;

   always_comb begin
      tl     = bank_rd[{b1_y0_odd_ff, b1_x0_odd_ff}];
      tr     = bank_rd[{b1_y0_odd_ff, b1_x1_odd_ff}];
      bl     = bank_rd[{b1_y1_odd_ff, b1_x0_odd_ff}];
      br     = bank_rd[{b1_y1_odd_ff, b1_x1_odd_ff}];
      inv_fx = UV_ONE - UV_BITS'(b1_fx_ff);
   end

   always_ff @(posedge clock) begin
      if (b1_valid_ff) begin
         b2_zero_ff <= b1_zero_ff;
         b2_fy_ff   <= b1_fy_ff;
         b2_p_tl_ff <= PROD_W'(tl) * PROD_W'(inv_fx);
         b2_p_tr_ff <= PROD_W'(tr) * PROD_W'(b1_fx_ff);
         b2_p_bl_ff <= PROD_W'(bl) * PROD_W'(inv_fx);
         b2_p_br_ff <= PROD_W'(br) * PROD_W'(b1_fx_ff);
      end
   end

   // stage 3: row lerp sums, truncated to 16 bits
   logic [LERP_W-1:0]        sum_top, sum_bot;
   logic                     b3_zero_ff;
   logic [FRAC_BITS-1:0]     b3_fy_ff;
   logic [COVERAGE_BITS-1:0] b3_top_ff, b3_bot_ff;

   always_comb begin
      sum_top = LERP_W'(b2_p_tl_ff) + LERP_W'(b2_p_tr_ff);
      sum_bot = LERP_W'(b2_p_bl_ff) + LERP_W'(b2_p_br_ff);
   end

   always_ff @(posedge clock) begin
      if (b2_valid_ff) begin
         b3_zero_ff <= b2_zero_ff;
         b3_fy_ff   <= b2_fy_ff;
         b3_top_ff  <= sum_top[FRAC_BITS +: COVERAGE_BITS];
         b3_bot_ff  <= sum_bot[FRAC_BITS +: COVERAGE_BITS];
      end
   end

   // stage 4: column lerp products
   logic [UV_BITS-1:0] inv_fy;
   logic               b4_zero_ff;
   logic [PROD2_W-1:0] b4_q_top_ff, b4_q_bot_ff;

   assign inv_fy = UV_ONE - UV_BITS'(b3_fy_ff);

   always_ff @(posedge clock) begin
      if (b3_valid_ff) begin
         b4_zero_ff  <= b3_zero_ff;
         b4_q_top_ff <= PROD2_W'(b3_top_ff) * PROD2_W'(inv_fy);
         b4_q_bot_ff <= PROD2_W'(b3_bot_ff) * PROD2_W'(b3_fy_ff);
      end
   end

   // final sum, saturate, zero when the texture is not ready
   logic [SUM2_W-1:0]        sum_col;
   logic [RES_W-1:0]         res;
   logic [COVERAGE_BITS-1:0] coverage;

   always_comb begin
      sum_col = SUM2_W'(b4_q_top_ff) + SUM2_W'(b4_q_bot_ff);
      res     = sum_col[SUM2_W-1:FRAC_BITS];
      if (b4_zero_ff) begin
         coverage = '0;
      end else if (res > RES_W'({COVERAGE_BITS{1'b1}})) begin
         coverage = '1;
      end else begin
         coverage = res[COVERAGE_BITS-1:0];
      end
   end

   // result buffer
   logic [COVERAGE_BITS-1:0] out_mem_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0]  out_wr_ff, out_rd_ff;
   logic                     out_pop;

   assign rsp_valid    = (out_count_ff != '0);
   assign out_pop      = rsp_valid & rsp_ready;
   assign rsp_coverage = out_mem_ff[out_rd_ff];
   assign out_count_in = out_count_ff + OUT_CNT_BITS'(b4_valid_ff) - OUT_CNT_BITS'(out_pop);

   always_ff @(posedge clock) begin
      if (b4_valid_ff) begin
         out_mem_ff[out_wr_ff] <= coverage;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         b4_valid_ff  <= 1'b0;
         out_count_ff <= '0;
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
      end else begin
         b1_valid_ff  <= sample_pop;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff;
         b4_valid_ff  <= b3_valid_ff;
         out_count_ff <= out_count_in;
         if (b4_valid_ff) begin
            out_wr_ff <= out_wr_ff + OUT_PTR_BITS'(1);
         end
         if (out_pop) begin
            out_rd_ff <= out_rd_ff + OUT_PTR_BITS'(1);
         end
      end
   end

endmodule

FILE: tb/sampler_board_pkg.sv
// ----------------------------------------------------------------------------
// sampler_board_pkg
// Item type, register codes and the coverage scoreboard of the sampler bench.
// The scoreboard keeps its own texel image and register copy. It works out
// the coverage of every accepted sample item and checks results in order.
// ----------------------------------------------------------------------------
package sampler_board_pkg;

   import bts_pkg::*;

   localparam int TEXEL_COUNT = 256 * 256;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_READY  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE  = 2'd3;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef struct {
      logic                         mode;
      logic [INDEX_BITS-1:0]        column;
      logic [INDEX_BITS-1:0]        row;
      logic [TEXEL_IN_BITS-1:0]     value;
      logic signed [COORD_BITS-1:0] coord_u;
      logic signed [COORD_BITS-1:0] coord_v;
   } texel_req_type;

   class sampler_board;
      bit [TEXEL_IN_BITS-1:0] texels [0:TEXEL_COUNT-1];
      logic [DIM_BITS-1:0]    width_reg;
      logic [DIM_BITS-1:0]    height_reg;
      logic                   ready_reg;
      logic [COVERAGE_BITS-1:0] expected_cov [$];
      int mismatches;
      int loads;
      int samples;
      int blind_samples;

      function new();
         width_reg     = DIM_BITS'(1);
         height_reg    = DIM_BITS'(1);
         ready_reg     = 1'b0;
         mismatches    = 0;
         loads         = 0;
         samples       = 0;
         blind_samples = 0;
      endfunction

      function void write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [DIM_BITS-1:0] data);
         case (idx)
            CSR_WIDTH:  width_reg = data;
            CSR_HEIGHT: height_reg = data;
            CSR_READY:  ready_reg = data[0];
            default: ;
         endcase
      endfunction

      static function int unsigned eff_dim(logic [DIM_BITS-1:0] dim);
         if (dim == 0) return 1;
         if (dim > 256) return 256;
         return int'(dim);
      endfunction

      static function int unsigned clamp_coord(logic signed [COORD_BITS-1:0] raw);
         if (raw[COORD_BITS-1]) return 0;
         if (raw[UV_BITS-1:0] > UV_ONE) return int'(UV_ONE);
         return int'(raw[UV_BITS-1:0]);
      endfunction

      // neighbor texels and fractions of a sample, clamped to the edge
      static function void find_corners(input logic signed [COORD_BITS-1:0] u,
                                        input logic signed [COORD_BITS-1:0] v,
                                        input logic [DIM_BITS-1:0] wreg,
                                        input logic [DIM_BITS-1:0] hreg,
                                        output int unsigned x0, output int unsigned x1,
                                        output int unsigned y0, output int unsigned y1,
                                        output int unsigned fx, output int unsigned fy);
         int unsigned w;
         int unsigned h;
         int unsigned sx;
         int unsigned sy;
         w  = eff_dim(wreg);
         h  = eff_dim(hreg);
         sx = clamp_coord(u) * (w - 1);
         sy = clamp_coord(v) * (h - 1);
         x0 = sx >> FRAC_BITS;
         y0 = sy >> FRAC_BITS;
         fx = sx & 32'hFFFF;
         fy = sy & 32'hFFFF;
         x1 = (x0 + 1 < w - 1) ? x0 + 1 : w - 1;
         y1 = (y0 + 1 < h - 1) ? y0 + 1 : h - 1;
      endfunction

      static function int unsigned blend(int unsigned a, int unsigned b, int unsigned f);
         longint unsigned wa;
         longint unsigned wb;
         longint unsigned wf;
         longint unsigned acc;
         wa  = a;
         wb  = b;
         wf  = f;
         acc = wa * (64'd65536 - wf) + wb * wf;
         return int'(acc >> FRAC_BITS);
      endfunction

      function void note_item(texel_req_type it);
         int unsigned x0, x1, y0, y1, fx, fy;
         int unsigned top, bot, res;
         if (it.mode == MODE_LOAD) begin
            texels[int'(it.row) * 256 + int'(it.column)] = it.value;
            loads++;
            return;
         end
         samples++;
         if (!ready_reg) begin
            blind_samples++;
            expected_cov.push_back('0);
            return;
         end
         find_corners(it.coord_u, it.coord_v, width_reg, height_reg, x0, x1, y0, y1, fx, fy);
         top = blend(texels[y0 * 256 + x0], texels[y0 * 256 + x1], fx) & 32'hFFFF;
         bot = blend(texels[y1 * 256 + x0], texels[y1 * 256 + x1], fx) & 32'hFFFF;
         res = blend(top, bot, fy);
         if (res > 32'hFFFF) res = 32'hFFFF;
         expected_cov.push_back(res[COVERAGE_BITS-1:0]);
      endfunction

      function void check_result(logic [COVERAGE_BITS-1:0] got);
         logic [COVERAGE_BITS-1:0] want;
         if (expected_cov.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result with nothing pending, coverage=%h", got);
            return;
         end
         want = expected_cov.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: coverage mismatch, expected %h got %h", want, got);
         end
      endfunction

      function int outstanding();
         return expected_cov.size();
      endfunction
   endclass

endpackage

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of bilinear_texel_sampler_core.
// Loads texels and samples UV pairs over a range of image sizes, with random
// gaps on the request side and random stalls on the result side, one long
// result hold-off included, and checks every coverage value in order.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bts_pkg::*;
   import sampler_board_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 24;
   localparam int CHOKE_CYCLES = 300;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [DIM_BITS-1:0] csr_wdata;
   logic req_valid;
   logic req_ready;
   logic req_mode;
   logic [INDEX_BITS-1:0] req_texel_column;
   logic [INDEX_BITS-1:0] req_texel_row;
   logic [TEXEL_IN_BITS-1:0] req_texel_value;
   logic signed [COORD_BITS-1:0] req_coord_u;
   logic signed [COORD_BITS-1:0] req_coord_v;
   logic rsp_valid;
   logic rsp_ready;
   logic [COVERAGE_BITS-1:0] rsp_coverage;

   sampler_board board;
   bit texel_loaded [0:TEXEL_COUNT-1];
   bit steady;
   bit choke_request;
   int chokes_done;
   int phase_items;
   int settings_run;
   int csr_writes;
   int cycle_count = 0;

   bilinear_texel_sampler_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_texel_column (req_texel_column),
      .req_texel_row    (req_texel_row),
      .req_texel_value  (req_texel_value),
      .req_coord_u      (req_coord_u),
      .req_coord_v      (req_coord_v),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_coverage     (rsp_coverage)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ERROR: run stopped after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // accepted items on both channels
   always @(posedge clock) begin
      texel_req_type seen;
      if (!reset) begin
         if (req_valid && req_ready) begin
            seen.mode    = req_mode;
            seen.column  = req_texel_column;
            seen.row     = req_texel_row;
            seen.value   = req_texel_value;
            seen.coord_u = req_coord_u;
            seen.coord_v = req_coord_v;
            board.note_item(seen);
         end
         if (rsp_valid && rsp_ready) board.check_result(rsp_coverage);
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      int stall;
      int r;
      stall     = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else if (choke_request) begin
            choke_request = 1'b0;
            chokes_done++;
            stall = CHOKE_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (steady) begin
            rsp_ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               if (r < 95) stall = $urandom_range(0, 3);
               else stall = $urandom_range(20, 60);
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [TEXEL_IN_BITS-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return TEXEL_IN_BITS'($urandom());
   endfunction

   function automatic logic signed [COORD_BITS-1:0] pick_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return COORD_BITS'($urandom_range(0, 65536));
      if (r < 74) return '0;
      if (r < 78) return 18'sd65536;
      if (r < 80) return 18'sh1FFFF;
      if (r < 82) return 18'sh20000;
      return COORD_BITS'($urandom());
   endfunction

   function automatic texel_req_type random_payload();
      texel_req_type it;
      it.mode    = MODE_LOAD;
      it.column  = INDEX_BITS'($urandom());
      it.row     = INDEX_BITS'($urandom());
      it.value   = TEXEL_IN_BITS'($urandom());
      it.coord_u = COORD_BITS'($urandom());
      it.coord_v = COORD_BITS'($urandom());
      return it;
   endfunction

   task automatic drive_item(input texel_req_type it);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= it.mode;
      req_texel_column <= it.column;
      req_texel_row    <= it.row;
      req_texel_value  <= it.value;
      req_coord_u      <= it.coord_u;
      req_coord_v      <= it.coord_v;
      do @(posedge clock); while (!req_ready);
      phase_items++;
   endtask

   task automatic send_load(input int unsigned col, input int unsigned row,
                            input logic [TEXEL_IN_BITS-1:0] value);
      texel_req_type it;
      it        = random_payload();
      it.mode   = MODE_LOAD;
      it.column = INDEX_BITS'(col);
      it.row    = INDEX_BITS'(row);
      it.value  = value;
      texel_loaded[row * 256 + col] = 1'b1;
      drive_item(it);
   endtask

   task automatic cover_texel(input int unsigned col, input int unsigned row);
      if (!texel_loaded[row * 256 + col]) send_load(col, row, pick_value());
   endtask

   // a sample never reads a texel that was not loaded first
   task automatic send_sample(input logic signed [COORD_BITS-1:0] u,
                              input logic signed [COORD_BITS-1:0] v);
      int unsigned x0, x1, y0, y1, fx, fy;
      texel_req_type it;
      if (board.ready_reg) begin
         sampler_board::find_corners(u, v, board.width_reg, board.height_reg,
                                     x0, x1, y0, y1, fx, fy);
         cover_texel(x0, y0);
         cover_texel(x1, y0);
         cover_texel(x0, y1);
         cover_texel(x1, y1);
      end
      it         = random_payload();
      it.mode    = MODE_SAMPLE;
      it.coord_u = u;
      it.coord_v = v;
      drive_item(it);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [DIM_BITS-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      board.write_csr(idx, data);
      csr_writes++;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // lower valid, let every result come back and the pipe empty out
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [DIM_BITS-1:0] wreg, input logic [DIM_BITS-1:0] hreg,
                            input logic ready_bit, input int items,
                            input bit quiet, input bit choke);
      int r;
      logic [DIM_BITS-1:0] ready_word;
      ready_word    = DIM_BITS'($urandom());
      ready_word[0] = ready_bit;
      csr_write(CSR_WIDTH, wreg);
      csr_write(CSR_HEIGHT, hreg);
      csr_write(CSR_READY, ready_word);
      csr_write(CSR_SPARE, DIM_BITS'($urandom()));
      settings_run++;
      steady        = quiet;
      choke_request = choke;
      phase_items   = 0;
      while (phase_items < items) begin
         r = $urandom_range(0, 99);
         if (r < 20) begin
            // stray load, often inside the active image
            if (r < 10)
               send_load($urandom_range(0, sampler_board::eff_dim(wreg) - 1),
                         $urandom_range(0, sampler_board::eff_dim(hreg) - 1), pick_value());
            else
               send_load($urandom_range(0, 255), $urandom_range(0, 255), pick_value());
         end else begin
            send_sample(pick_coord(), pick_coord());
         end
      end
      settle();
      steady = 1'b0;
   endtask

   initial begin : stimulus
      int i;
      reset            = 1'b1;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_valid        = 1'b0;
      req_mode         = MODE_LOAD;
      req_texel_column = '0;
      req_texel_row    = '0;
      req_texel_value  = '0;
      req_coord_u      = '0;
      req_coord_v      = '0;
      steady           = 1'b0;
      choke_request    = 1'b0;
      chokes_done      = 0;
      settings_run     = 1;
      csr_writes       = 0;
      board            = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: texture not ready, samples give zero
      send_sample(-18'sd131072, 18'sd131071);
      send_sample(0, 0);
      send_load(0, 0, 16'hFFFF);
      send_load(255, 255, 16'h0000);
      send_load(255, 0, 16'h8000);
      send_load(0, 255, 16'h0001);
      settle();

      // zero sizes act as one texel; the spare index is ignored
      csr_write(CSR_SPARE, 9'h1FF);
      csr_write(CSR_WIDTH, 9'd0);
      csr_write(CSR_HEIGHT, 9'd0);
      csr_write(CSR_READY, 9'd1);
      settings_run++;
      send_sample(18'sd131071, -18'sd1);
      send_sample(18'sd65536, 18'sd65536);
      settle();

      // full image: far corner, just inside it, edges, out-of-range UV
      csr_write(CSR_WIDTH, 9'd256);
      csr_write(CSR_HEIGHT, 9'd256);
      settings_run++;
      send_sample(18'sd65536, 18'sd65536);
      send_sample(18'sd65535, 18'sd65535);
      send_sample(18'sd0, 18'sd65536);
      send_sample(18'sd65537, -18'sd5);
      // full-scale texels blended with nonzero fractions
      for (i = 0; i < 4; i++) send_load(10 + i % 2, 20 + i / 2, 16'hFFFF);
      send_sample(18'sd2700, 18'sd5200);
      send_sample(18'sd32768, 18'sd16384);
      settle();

      // random part
      run_phase(9'd256, 9'd256, 1'b1, 100, 1'b1, 1'b1);
      run_phase(9'd511, 9'd2, 1'b1, 60, 1'b0, 1'b0);
      run_phase(9'd2, 9'd3, 1'b1, 80, 1'b0, 1'b0);
      run_phase(9'd17, 9'd5, 1'b1, 80, 1'b1, 1'b0);
      run_phase(9'd256, 9'd1, 1'b1, 60, 1'b0, 1'b0);
      run_phase(9'd1, 9'd1, 1'b0, 50, 1'b0, 1'b0);
      run_phase(9'd5, 9'd257, 1'b1, 70, 1'b0, 1'b0);
      run_phase(DIM_BITS'($urandom_range(1, 16)), DIM_BITS'($urandom_range(1, 16)),
                1'b1, 65, 1'b0, 1'b0);
      run_phase(DIM_BITS'($urandom_range(0, 511)), DIM_BITS'($urandom_range(1, 8)),
                1'b1, 65, 1'b0, 1'b0);
      run_phase(DIM_BITS'($urandom_range(1, 8)), DIM_BITS'($urandom_range(1, 8)),
                1'($urandom_range(0, 1)), 65, 1'b0, 1'b0);

      $display("Run covered %0d loads and %0d samples (%0d with texture not ready)",
               board.loads, board.samples, board.blind_samples);
      $display("over %0d register settings, %0d csr writes, %0d result hold-offs of %0d cycles",
               settings_run, csr_writes, chokes_done, CHOKE_CYCLES);
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("ERROR: %0d mismatches, %0d results missing",
                  board.mismatches, board.outstanding());
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
